>>> design/hfbp_pkg.sv
// Shared constants, configuration and result types for the header framed byte parser.
package hfbp_pkg;

    localparam int FRAME_BYTES = 10;
    localparam int FILL_W      = $clog2(FRAME_BYTES + 1);
    localparam int PUBLISH_MIN = 5;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_FIRST_HEADER  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_HEADER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_MARKER    = 2'd2;

    localparam logic [7:0] FIRST_HEADER_RST  = 8'h2C;
    localparam logic [7:0] SECOND_HEADER_RST = 8'h12;
    localparam logic [7:0] END_MARKER_RST    = 8'h5B;

    localparam int TDATA_W = 48;

    typedef struct packed {
        logic [7:0] first_header;
        logic [7:0] second_header;
        logic [7:0] end_marker;
    } t_cfg;

    typedef struct packed {
        logic [15:0] frame_total;
        logic [7:0]  extra_value;
        logic [7:0]  found_mark;
        logic [7:0]  pos_y;
        logic [7:0]  pos_x;
        logic        frame_done;
    } t_result;

endpackage

>>> design/hfbp_parser.sv
// Frame hunt and collect state machine with held publish values and frame counter.
module hfbp_parser
    import hfbp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    output t_result    o_res
);

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_EXPECT  = 2'd1,
        PH_COLLECT = 2'd2,
        PH_REARM   = 2'd3
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [FILL_W-1:0] r_fill, n_fill;
    // last four stored bytes, newest at index 0
    logic [7:0]        r_hist [4];
    logic [7:0]        n_hist [4];
    logic [7:0]        r_held_x, r_held_y, r_held_found, r_held_extra;
    logic [7:0]        n_held_x, n_held_y, n_held_found, n_held_extra;
    logic [15:0]       r_total, n_total;
    logic              n_done;
    logic              w_room;
    logic [FILL_W-1:0] w_fill_inc;

    assign w_room     = (r_fill < FILL_W'(FRAME_BYTES));
    assign w_fill_inc = r_fill + FILL_W'(1);

    always_comb begin
        n_phase      = r_phase;
        n_fill       = r_fill;
        n_hist       = r_hist;
        n_held_x     = r_held_x;
        n_held_y     = r_held_y;
        n_held_found = r_held_found;
        n_held_extra = r_held_extra;
        n_total      = r_total;
        n_done       = 1'b0;
        case (r_phase)
            PH_HUNT: begin
                if (i_byte == i_cfg.first_header) begin
                    n_fill    = FILL_W'(1);
                    n_hist[0] = i_byte;
                    n_hist[1] = r_hist[0];
                    n_hist[2] = r_hist[1];
                    n_hist[3] = r_hist[2];
                    n_phase   = PH_EXPECT;
                end else begin
                    n_fill  = '0;
                    n_phase = PH_HUNT;
                end
            end
            PH_EXPECT: begin
                if (i_byte == i_cfg.second_header) begin
                    if (w_room) begin
                        n_fill    = w_fill_inc;
                        n_hist[0] = i_byte;
                        n_hist[1] = r_hist[0];
                        n_hist[2] = r_hist[1];
                        n_hist[3] = r_hist[2];
                    end
                    n_phase = PH_COLLECT;
                end else begin
                    n_fill  = '0;
                    n_phase = PH_HUNT;
                end
            end
            PH_COLLECT: begin
                if (w_room) begin
                    n_fill    = w_fill_inc;
                    n_hist[0] = i_byte;
                    n_hist[1] = r_hist[0];
                    n_hist[2] = r_hist[1];
                    n_hist[3] = r_hist[2];
                end
                if (n_fill >= FILL_W'(FRAME_BYTES) || i_byte == i_cfg.end_marker) begin
                    n_phase = PH_REARM;
                    // short frames end without publishing
                    if (n_fill >= FILL_W'(PUBLISH_MIN)) begin
                        n_held_x     = r_hist[3];
                        n_held_y     = r_hist[2];
                        n_held_found = r_hist[1];
                        n_held_extra = r_hist[0];
                        n_total      = r_total + 16'd1;
                        n_done       = 1'b1;
                    end
                end
            end
            default: begin
                n_fill  = '0;
                n_phase = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HUNT;
            r_fill       <= '0;
            r_held_x     <= '0;
            r_held_y     <= '0;
            r_held_found <= '0;
            r_held_extra <= '0;
            r_total      <= '0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_fill       <= n_fill;
            r_held_x     <= n_held_x;
            r_held_y     <= n_held_y;
            r_held_found <= n_held_found;
            r_held_extra <= n_held_extra;
            r_total      <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_hist <= n_hist;
        end
    end

    assign o_res.frame_total = n_total;
    assign o_res.extra_value = n_held_extra;
    assign o_res.found_mark  = n_held_found;
    assign o_res.pos_y       = n_held_y;
    assign o_res.pos_x       = n_held_x;
    assign o_res.frame_done  = n_done;

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(FRAME_BYTES))
        else $error("fill count past frame size");

    a_done_rearms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_res.frame_done |=> r_phase == PH_REARM)
        else $error("published frame did not enter rearm");

    a_rearm_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && r_phase == PH_REARM |=> r_phase == PH_HUNT && r_fill == '0)
        else $error("rearm byte did not restart the hunt");

    a_total_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && !o_res.frame_done |=> $stable(r_total))
        else $error("frame counter moved without a published frame");

    a_done_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_res.frame_done |-> r_phase == PH_COLLECT
            && r_fill >= FILL_W'(PUBLISH_MIN - 1))
        else $error("publish from a short frame");
`endif

endmodule

>>> design/header_framed_byte_parser.sv
// Top level: stream handshake, configuration registers and result register of the parser.
// Usage:
//   Slave stream (i_s_*) carries one received serial byte per item in tdata.
//   Master stream (o_m_*) returns exactly one result item per input item: the
//   last published coordinate bytes and frame count in tdata, and in tuser a
//   flag set when that byte completed and published a frame.
//   Configuration: write i_cfg_data to register i_cfg_idx while i_cfg_we is
//   high (0 first header, 1 second header, 2 end marker); other indexes are
//   ignored. Write only while no item is in flight.
//   A result passes through the input register, then the result register, and
//   is valid once the result register has taken it; a receiver stall can hold
//   it in the input register. Throughput: one item per cycle while the receiver
//   does not stall, with the parser's combinational step between the two registers.
//   Reset (i_rst_n low, synchronous): headers and end marker return to their
//   defaults, the parser hunts for the first header, held bytes and frame
//   count are zero, and both register stages are empty.
//   Receiver stall: the result register holds its item and the input register
//   still takes one more item; then o_s_tready drops until the stall clears.
module header_framed_byte_parser
    import hfbp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [7:0]            i_s_tdata,   // [7:0] rx_byte
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // [7:0] pos_x, [15:8] pos_y, [23:16] found_mark, [31:24] extra_value,
    // [47:32] frame_total
    output logic [TDATA_W-1:0]    o_m_tdata,
    output logic                  o_m_tuser,   // [0] frame_done
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg       r_cfg;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    t_result    w_res;
    logic       w_adv;
    logic       w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.first_header  <= FIRST_HEADER_RST;
            r_cfg.second_header <= SECOND_HEADER_RST;
            r_cfg.end_marker    <= END_MARKER_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FIRST_HEADER:  r_cfg.first_header  <= i_cfg_data;
                REG_SECOND_HEADER: r_cfg.second_header <= i_cfg_data;
                REG_END_MARKER:    r_cfg.end_marker    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_adv      = !r_out_valid || i_m_tready;
    assign w_step     = r_in_valid && w_adv;
    assign o_s_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_s_tvalid && o_s_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_byte <= i_s_tdata;
        end
    end

    hfbp_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_step  (w_step),
        .i_byte  (r_in_byte),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out.frame_total, r_out.extra_value, r_out.found_mark,
                         r_out.pos_y, r_out.pos_x};
    assign o_m_tuser  = r_out.frame_done;

endmodule
